>>> rtl/bca_pkg.sv
package bca_pkg;

  // Pool geometry
  localparam int MAX_CELLS = 256;
  localparam int WORD_BITS = 16;
  localparam int NUM_WORDS = (MAX_CELLS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW   = $clog2(NUM_WORDS);
  localparam int BIT_AW    = $clog2(WORD_BITS);

  // Field widths
  localparam int CMD_W    = 2;
  localparam int CELL_W   = 9;
  localparam int BYTES_W  = 13;
  localparam int OFF_W    = 20;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 13;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 48;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CELL_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_BYTES = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CELL,
    ST_OUT
  } state_t;

endpackage

>>> rtl/bitmap_cell_allocator_core.sv
// Fixed-cell pool allocator with an occupancy bitmap held in a 16 x 16 memory.
// Input channel s_axis carries one command item (acquire, release, query);
// output channel m_axis returns exactly one result item for each command.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user
// must keep to writing it while idle, as the block does not enforce it.
// Index 0 sets the cell limit, index 1 the cell size in bytes.
// One item is worked on at a time. From input accept to result valid:
//   pool full, invalid cell or unused command: straight to the result;
//   release or query: one bitmap read, check, write back, then the result;
//   acquire: a scan from word 0 up to the word holding the lowest free cell,
//   or to the last word within the limit; one memory word is read per cycle.
// The input is ready again in the cycle after the result is loaded, so the
// next item may be taken while the previous result still waits downstream.
// If the receiver stalls and the output register is full, the finished
// result waits inside until the register is taken.
// Reset (rst, synchronous) clears the per-word valid flags, so every cell
// reads as free at once; no clearing pass is needed. Count goes to zero,
// limit to 256 cells and cell size to 16 bytes.
module bitmap_cell_allocator_core
  import bca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [1:0] cmd, [10:2] cell_number, [15:11] zero
  input  logic [IN_W-1:0]       s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] status, [10:2] cell_out, [30:11] byte_offset, [31] occupied,
  // [40:32] used_count, [47:41] zero
  output logic [OUT_W-1:0]      m_axis_tdata
);

  localparam int ZIDX_W = WORD_AW + BIT_AW;

  // Configuration and control registers
  logic [CELL_W-1:0]    cell_limit;
  logic [BYTES_W-1:0]   cell_bytes;
  logic [CELL_W-1:0]    used;
  state_t               state, state_next;

  // Item registers
  logic [CMD_W-1:0]     item_cmd;
  logic [CELL_W-1:0]    item_cell;
  logic [WORD_AW-1:0]   scan_word;
  logic [WORD_AW-1:0]   chk_word;

  // Result registers
  logic [STATUS_W-1:0]  res_status;
  logic [CELL_W-1:0]    res_cell;
  logic                 res_busy;
  logic                 out_valid;

  // Bitmap memory with per-word valid flags
  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] word_valid;
  logic [WORD_BITS-1:0] mem_rdata;
  logic                 mem_rvalid;
  logic [WORD_BITS-1:0] rword;
  logic [WORD_AW-1:0]   raddr;
  logic                 mem_we;
  logic [WORD_AW-1:0]   waddr;
  logic [WORD_BITS-1:0] wdata;

  // Derived values
  logic [CELL_W-1:0]    lim;
  logic [CELL_W-1:0]    lim_m1;
  logic [WORD_AW-1:0]   last_word;
  logic [CMD_W-1:0]     in_cmd;
  logic [CELL_W-1:0]    in_cell;
  logic [CELL_W-1:0]    in_z;
  logic                 in_valid_cell;
  logic [CELL_W-1:0]    item_z;
  logic                 accept;
  logic                 out_load;
  logic                 hit;
  logic [BIT_AW-1:0]    hit_bit;
  logic                 cell_bit;
  logic [CELL_W-1:0]    off_idx;
  logic [BYTES_W+CELL_W-1:0] prod;

  assign lim       = (cell_limit > CELL_W'(MAX_CELLS)) ? CELL_W'(MAX_CELLS) : cell_limit;
  assign lim_m1    = lim - CELL_W'(1);
  assign last_word = lim_m1[ZIDX_W-1:BIT_AW];

  assign in_cmd        = s_axis_tdata[CMD_W-1:0];
  assign in_cell       = s_axis_tdata[CMD_W+CELL_W-1:CMD_W];
  assign in_z          = in_cell - CELL_W'(1);
  assign in_valid_cell = (in_cell != '0) && (in_cell <= lim);
  assign item_z        = item_cell - CELL_W'(1);

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == ST_OUT) && (!out_valid || m_axis_tready);
  assign m_axis_tvalid = out_valid;

  // Words never written since reset read as all free
  assign rword    = mem_rvalid ? mem_rdata : '0;
  assign cell_bit = rword[item_z[BIT_AW-1:0]];

  // Find the lowest free cell of the checked word that lies below the limit
  always_comb begin
    hit     = 1'b0;
    hit_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!rword[b] && ({1'b0, chk_word, BIT_AW'(b)} < lim)) begin
        hit     = 1'b1;
        hit_bit = BIT_AW'(b);
      end
    end
  end

  // Read address: word of the incoming cell, word 0 for an acquire, or the scan pointer
  always_comb begin
    if (state == ST_SCAN) begin
      raddr = scan_word;
    end else if (in_cmd == CMD_ACQUIRE) begin
      raddr = '0;
    end else begin
      raddr = in_z[ZIDX_W-1:BIT_AW];
    end
  end

  // Write back: set the found bit, or clear a released one
  always_comb begin
    mem_we = 1'b0;
    waddr  = chk_word;
    wdata  = rword | (WORD_BITS'(1) << hit_bit);
    if (state == ST_SCAN) begin
      mem_we = hit;
    end else if (state == ST_CELL) begin
      waddr  = item_z[ZIDX_W-1:BIT_AW];
      wdata  = rword & ~(WORD_BITS'(1) << item_z[BIT_AW-1:0]);
      mem_we = (item_cmd == CMD_RELEASE) && cell_bit;
    end
  end

  // Bitmap memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    mem_rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      mem_rvalid <= 1'b0;
    end else begin
      if (mem_we) begin
        word_valid[waddr] <= 1'b1;
      end
      mem_rvalid <= word_valid[raddr];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_limit <= CELL_W'(256);
      cell_bytes <= BYTES_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELL_LIMIT: cell_limit <= cfg_data[CELL_W-1:0];
        REG_CELL_BYTES: cell_bytes <= cfg_data[BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_ACQUIRE) begin
            state_next = (used >= lim) ? ST_OUT : ST_SCAN;
          end else if ((in_cmd == CMD_RELEASE || in_cmd == CMD_QUERY) && in_valid_cell) begin
            state_next = ST_CELL;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_SCAN: begin
        if (hit || chk_word == last_word) begin
          state_next = ST_OUT;
        end
      end
      ST_CELL: state_next = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Occupied count
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (state == ST_SCAN && hit) begin
      used <= used + CELL_W'(1);
    end else if (state == ST_CELL && mem_we && used != '0) begin
      used <= used - CELL_W'(1);
    end
  end

  // Item capture, scan pointers and result
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        item_cmd   <= in_cmd;
        item_cell  <= in_cell;
        scan_word  <= WORD_AW'(1);
        chk_word   <= '0;
        res_cell   <= '0;
        res_busy   <= 1'b0;
        res_status <= (in_cmd == CMD_ACQUIRE) ? STAT_FULL : STAT_BAD;
      end
      ST_SCAN: begin
        scan_word <= scan_word + WORD_AW'(1);
        chk_word  <= chk_word + WORD_AW'(1);
        if (hit) begin
          res_status <= STAT_OK;
          res_cell   <= {1'b0, chk_word, hit_bit} + CELL_W'(1);
          res_busy   <= 1'b1;
        end
      end
      ST_CELL: begin
        if (item_cmd == CMD_QUERY) begin
          res_status <= STAT_OK;
          res_cell   <= item_cell;
          res_busy   <= cell_bit;
        end else if (cell_bit) begin
          res_status <= STAT_OK;
          res_cell   <= item_cell;
        end
      end
      default: ;
    endcase
  end

  // Byte offset of the result cell
  assign off_idx = (res_cell == '0) ? '0 : res_cell - CELL_W'(1);
  assign prod    = cell_bytes * off_idx;

  // Output register: load when empty or being taken, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {7'd0, used, res_busy, prod[OFF_W-1:0], res_cell, res_status};
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CELL_W'(MAX_CELLS))
    else $error("occupied count above pool size");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("second item taken while one is at work");

  a_write_then_out: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> state == ST_OUT)
    else $error("bitmap written without finishing the item");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_SCAN || state == ST_CELL))
    else $error("bitmap written outside scan or cell check");

endmodule

>>> bench/testbench.sv
module testbench
  import bca_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int PAD_W = OUT_W - STATUS_W - 2 * CELL_W - OFF_W - 1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int DRAIN_CYCLES = 20;

  // One result item, laid out as on m_axis_tdata (last member in the lowest bits)
  typedef struct packed {
    logic [PAD_W-1:0]    pad;
    logic [CELL_W-1:0]   used_count;
    logic                occupied;
    logic [OFF_W-1:0]    byte_offset;
    logic [CELL_W-1:0]   cell_out;
    logic [STATUS_W-1:0] status;
  } outcome_t;

  // Shadow of the pool: bitmap, count and registers, plus the outcomes still owed
  class pool_scoreboard;
    logic [MAX_CELLS-1:0] cell_map;
    int unsigned          used_cells;
    logic [CELL_W-1:0]    limit_reg;
    logic [BYTES_W-1:0]   bytes_reg;
    outcome_t             pending_outcomes[$];
    int unsigned          mismatches;

    function new();
      cell_map   = '0;
      used_cells = 0;
      limit_reg  = CELL_W'(MAX_CELLS);
      bytes_reg  = BYTES_W'(16);
      mismatches = 0;
    endfunction

    function void set_register(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
      if (idx == REG_CELL_LIMIT) limit_reg = value[CELL_W-1:0];
      else if (idx == REG_CELL_BYTES) bytes_reg = value[BYTES_W-1:0];
    endfunction

    // A limit above the pool size acts as the pool size
    function int unsigned usable_cells();
      return (limit_reg > MAX_CELLS) ? MAX_CELLS : int'(limit_reg);
    endfunction

    // Work out the outcome of an accepted command and update the shadow pool
    function void apply_command(input logic [CMD_W-1:0] cmd,
                                input logic [CELL_W-1:0] cell_num);
      int unsigned lim;
      int unsigned product;
      bit          in_range;
      bit          found;
      outcome_t    want;
      lim      = usable_cells();
      in_range = (cell_num >= 1) && (cell_num <= lim);
      found    = 1'b0;
      want     = '0;
      want.status = STAT_BAD;
      case (cmd)
        CMD_ACQUIRE: begin
          want.status = STAT_FULL;
          if (used_cells < lim) begin
            for (int unsigned c = 1; c <= lim; c++) begin
              if (!found && !cell_map[c-1]) begin
                found         = 1'b1;
                cell_map[c-1] = 1'b1;
                used_cells++;
                want.status   = STAT_OK;
                want.cell_out = CELL_W'(c);
                want.occupied = 1'b1;
              end
            end
          end
        end
        CMD_RELEASE: begin
          if (in_range && cell_map[cell_num-1]) begin
            cell_map[cell_num-1] = 1'b0;
            if (used_cells > 0) used_cells--;
            want.status   = STAT_OK;
            want.cell_out = cell_num;
          end
        end
        CMD_QUERY: begin
          if (in_range) begin
            want.status   = STAT_OK;
            want.cell_out = cell_num;
            want.occupied = cell_map[cell_num-1];
          end
        end
        default: want.status = STAT_BAD;
      endcase
      // Offset wraps at the field width
      if (want.cell_out != 0) begin
        product          = int'(bytes_reg) * (int'(want.cell_out) - 1);
        want.byte_offset = product[OFF_W-1:0];
      end
      want.used_count = CELL_W'(used_cells);
      pending_outcomes.push_back(want);
    endfunction

    task report(input string what, input int unsigned got, input int unsigned want);
      $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
      mismatches++;
    endtask

    // Compare a result item with the oldest outcome owed
    task compare_outcome(input logic [OUT_W-1:0] data);
      outcome_t got;
      outcome_t want;
      got = data;
      if (pending_outcomes.size() == 0) begin
        report("result item with nothing pending, cell_out", got.cell_out, 0);
      end else begin
        want = pending_outcomes.pop_front();
        if (got.status != want.status) report("status", got.status, want.status);
        if (got.cell_out != want.cell_out) report("cell_out", got.cell_out, want.cell_out);
        if (got.byte_offset != want.byte_offset)
          report("byte_offset", got.byte_offset, want.byte_offset);
        if (got.occupied != want.occupied) report("occupied", got.occupied, want.occupied);
        if (got.used_count != want.used_count)
          report("used_count", got.used_count, want.used_count);
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // [1:0] cmd, [10:2] cell_number, [15:11] zero
  logic [IN_W-1:0]       s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // [1:0] status, [10:2] cell_out, [30:11] byte_offset, [31] occupied,
  // [40:32] used_count, [47:41] zero
  logic [OUT_W-1:0]      m_axis_tdata;

  pool_scoreboard sb = new();
  bit             quiet_run = 1'b0;
  bit             hold_request = 1'b0;
  int unsigned    cycle_count = 0;

  bitmap_cell_allocator_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Note accepted commands and check returned items at the rising edge
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      sb.apply_command(s_axis_tdata[CMD_W-1:0], s_axis_tdata[CMD_W +: CELL_W]);
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.compare_outcome(m_axis_tdata);
  end

  // Receiver: random stall bursts, one long hold-off on request, none when quiet
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        for (int n = 0; n < HOLD_OFF_CYCLES; n++) @(negedge clk);
      end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Offer one command and hold it until taken; maybe idle afterwards
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CELL_W-1:0] cell_num);
    s_axis_tdata  <= {{(IN_W - CELL_W - CMD_W){1'b0}}, cell_num, cmd};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    if (!quiet_run && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // Stop offering and wait for every owed item, then let the block settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_outcomes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, value);
    @(negedge clk);
  endtask

  task automatic set_pool(input int unsigned limit, input int unsigned bytes);
    write_reg(REG_CELL_LIMIT, CFG_DATA_W'(limit));
    write_reg(REG_CELL_BYTES, CFG_DATA_W'(bytes));
  endtask

  // Pick a cell within the limit (any number when the limit is zero), preferably an occupied one when asked
  function automatic logic [CELL_W-1:0] pick_cell(input int unsigned lim, input bit want_busy);
    logic [CELL_W-1:0] c;
    if (lim == 0) return CELL_W'($urandom_range(0, 511));
    c = CELL_W'($urandom_range(1, lim));
    for (int t = 0; t < 16 && want_busy && !sb.cell_map[c-1]; t++)
      c = CELL_W'($urandom_range(1, lim));
    return c;
  endfunction

  // Mostly well-formed traffic: acquires, releases of held cells, queries, some noise
  task automatic random_phase(input int unsigned items, input int unsigned acquire_pct);
    int unsigned roll;
    int unsigned spare;
    int unsigned lim;
    spare = 100 - acquire_pct;
    for (int unsigned i = 0; i < items; i++) begin
      roll = $urandom_range(0, 99);
      lim  = sb.usable_cells();
      if (roll < acquire_pct)
        send_item(CMD_ACQUIRE, CELL_W'($urandom_range(0, 511)));
      else if (roll < acquire_pct + spare / 2)
        send_item(CMD_RELEASE, pick_cell(lim, 1'b1));
      else if (roll < acquire_pct + spare * 4 / 5)
        send_item(CMD_QUERY, pick_cell(lim, bit'($urandom_range(0, 1))));
      else
        send_item(CMD_W'($urandom_range(0, 3)), CELL_W'($urandom_range(0, 511)));
    end
  endtask

  initial begin
    int unsigned limit;
    int unsigned bytes;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Bad cell numbers, free cells, the unused command, then a few allocations
    send_item(CMD_QUERY, CELL_W'(0));
    send_item(CMD_RELEASE, CELL_W'(0));
    send_item(CMD_QUERY, CELL_W'(256));
    send_item(CMD_QUERY, CELL_W'(257));
    send_item(CMD_QUERY, CELL_W'(511));
    send_item(CMD_RELEASE, CELL_W'(5));
    send_item(CMD_SPARE, CELL_W'(511));
    send_item(CMD_ACQUIRE, CELL_W'(0));
    send_item(CMD_ACQUIRE, CELL_W'(511));
    send_item(CMD_ACQUIRE, CELL_W'(0));
    send_item(CMD_RELEASE, CELL_W'(2));
    send_item(CMD_ACQUIRE, CELL_W'(0));
    send_item(CMD_QUERY, CELL_W'(2));
    send_item(CMD_RELEASE, CELL_W'(2));
    send_item(CMD_RELEASE, CELL_W'(2));
    drain_results();

    // Lowered limit: occupied cells above it are out of reach, pool reads full
    set_pool(1, 16);
    send_item(CMD_ACQUIRE, CELL_W'(0));
    send_item(CMD_QUERY, CELL_W'(3));
    send_item(CMD_RELEASE, CELL_W'(1));
    send_item(CMD_ACQUIRE, CELL_W'(0));
    drain_results();

    // Zero limit: nothing valid, always full
    set_pool(0, 16);
    send_item(CMD_ACQUIRE, CELL_W'(0));
    send_item(CMD_QUERY, CELL_W'(1));
    drain_results();

    // Oversized limit with largest cell size: offsets wrap
    set_pool(511, 8191);
    send_item(CMD_ACQUIRE, CELL_W'(0));
    send_item(CMD_QUERY, CELL_W'(256));
    send_item(CMD_RELEASE, CELL_W'(3));
    drain_results();
    write_reg(REG_CELL_BYTES, CFG_DATA_W'(4096));
    send_item(CMD_QUERY, CELL_W'(256));
    drain_results();

    // Fill the whole pool, with a long output hold-off at the start
    set_pool(MAX_CELLS, $urandom_range(1, 4096));
    hold_request = 1'b1;
    random_phase(300, 92);
    drain_results();

    // Drop the limit below the filled region
    set_pool(40, 1);
    random_phase(50, 30);
    drain_results();

    // Random settings, extremes included
    for (int p = 0; p < 5; p++) begin
      case ($urandom_range(0, 4))
        0:       limit = $urandom_range(1, 64);
        1:       limit = 0;
        2:       limit = $urandom_range(257, 511);
        3:       limit = MAX_CELLS;
        default: limit = $urandom_range(1, MAX_CELLS);
      endcase
      case ($urandom_range(0, 3))
        0:       bytes = 1;
        1:       bytes = 4096;
        2:       bytes = 8191;
        default: bytes = $urandom_range(1, 4096);
      endcase
      set_pool(limit, bytes);
      if (p == 4) quiet_run = 1'b1;
      random_phase(50, 50);
      drain_results();
    end

    if (sb.mismatches == 0 && sb.pending_outcomes.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> bitmap_cell_allocator_core.f
rtl/bca_pkg.sv
rtl/bitmap_cell_allocator_core.sv
bench/testbench.sv
